[design/rc_receiver_frame_decoder_top_assert.svh]
// assertion macros for the rc frame decoder checker
// no dependencies; included by rcfd_checker.sv
`ifndef RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define RCFD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCFD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rcfd_pkg.sv]
// shared types and constants for the rc frame decoder
// no dependencies; imported by every module of the block
`default_nettype none

package rcfd_pkg;

    localparam int FRAME_BYTES  = 18;
    localparam int BUFFER_LIMIT = 36;
    localparam int COUNT_W      = 6;
    localparam int IDX_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [10:0] OFFSET_RESET   = 11'd1024;
    localparam logic [9:0]  DEADBAND_RESET = 10'd5;
    localparam logic [10:0] LIMIT_RESET    = 11'd670;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_IDLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_OFFSET = 2'd0,
        REG_DEADBAND       = 2'd1,
        REG_ABNORMAL_LIMIT = 2'd2
    } cfg_reg_e;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [10:0] channel_offset;
        logic [9:0]  deadband;
        logic [10:0] abnormal_limit;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic signed [11:0] stick_0;
        logic signed [11:0] stick_1;
        logic signed [11:0] stick_2;
        logic signed [11:0] stick_3;
        logic signed [15:0] wheel_channel;
        logic        [3:0]  switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic        [7:0]  button_left;
        logic        [7:0]  button_right;
        logic        [15:0] key_bits;
    } out_word_t;

endpackage

`default_nettype wire

[design/rcfd_frame_buffer.sv]
// byte store, burst counter and pending-frame flag
// depends on rcfd_pkg
`default_nettype none

module rcfd_frame_buffer
    import rcfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire in_word_t in_data,
    input  wire logic     drain,
    output logic          in_stall,
    output logic          pending,
    output frame_t        frame
);

    frame_t               store_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 pending_reg;
    logic                 pending_next;
    logic                 accept;

    // a frame waiting on a full result register freezes the store
    assign in_stall = pending_reg && !drain;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg && !drain;
        if (accept)
        begin
            if (in_data.mode == MODE_IDLE)
            begin
                count_next   = '0;
                pending_next = (count_reg == COUNT_W'(FRAME_BYTES));
            end
            else if (count_reg < COUNT_W'(BUFFER_LIMIT))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.mode == MODE_BYTE && count_reg < COUNT_W'(FRAME_BYTES))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= in_data.rx_byte;
        end
    end

    assign pending = pending_reg;
    assign frame   = store_reg;

endmodule

`default_nettype wire

[design/rcfd_frame_decode.sv]
// field unpack, offset, deadband and abnormal-stick check of one frame
// depends on rcfd_pkg
`default_nettype none

module rcfd_frame_decode
    import rcfd_pkg::*;
(
    input  wire frame_t frame,
    input  wire cfg_t   cfg,
    output out_word_t   result
);

    logic [10:0]        raw [4];
    logic signed [11:0] ch [4];
    logic [10:0]        ch_mag [4];
    logic [15:0]        wheel_diff;
    logic [15:0]        wheel_mag;
    logic signed [15:0] wheel;
    logic               abnormal;

    always_comb
    begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        for (int k = 0; k < 4; k++)
        begin
            ch[k]     = $signed({1'b0, raw[k]} - {1'b0, cfg.channel_offset});
            ch_mag[k] = ch[k][11] ? 11'(-ch[k]) : ch[k][10:0];
            if (ch_mag[k] < {1'b0, cfg.deadband})
            begin
                ch[k]     = '0;
                ch_mag[k] = '0;
            end
        end

        // wheel wraps at 16 bits, -32768 has magnitude 32768
        wheel_diff = {frame[17], frame[16]} - {5'd0, cfg.channel_offset};
        wheel_mag  = wheel_diff[15] ? (~wheel_diff + 16'd1) : wheel_diff;
        wheel      = (wheel_mag < {6'd0, cfg.deadband}) ? '0 : $signed(wheel_diff);

        abnormal = (ch_mag[0] > cfg.abnormal_limit) || (ch_mag[3] > cfg.abnormal_limit);

        if (abnormal)
        begin
            result = '0;
        end
        else
        begin
            result.stick_0       = ch[0];
            result.stick_1       = ch[1];
            result.stick_2       = ch[2];
            result.stick_3       = ch[3];
            result.wheel_channel = wheel;
            result.switches      = frame[5][7:4];
            result.mouse_x       = $signed({frame[7], frame[6]});
            result.mouse_y       = $signed({frame[9], frame[8]});
            result.mouse_z       = $signed({frame[11], frame[10]});
            result.button_left   = frame[12];
            result.button_right  = frame[13];
            result.key_bits      = {frame[15], frame[14]};
        end
    end

endmodule

`default_nettype wire

[design/rc_receiver_frame_decoder_top.sv]
// rc receiver frame decoder: in channel of bytes and idle events, out channel of
// decoded frames, config write port; depends on rcfd_pkg, rcfd_frame_buffer,
// rcfd_frame_decode
//
// in channel: in_valid/in_stall with in_data (mode, rx_byte). mode 0 stores a byte
// into the 18-entry frame store and bumps the burst count (saturating at 36),
// mode 1 closes the burst; when exactly 18 bytes came in a frame is decoded.
// out channel: out_valid/out_stall with out_data, one word per 18-byte frame (all zero when a stick is abnormal).
// config: cfg_valid/cfg_ready (always ready), cfg_index 0 offset, 1 deadband,
// 2 abnormal limit; other indexes are dropped. write only while idle.
// order: the idle event sets the pending flag, then the decoded word is registered
// and shows on out_valid; one item per cycle is accepted while in_stall is low, set
// by the single frame-ready flag between the frame store and the result register.
// stall: the result register holds while out_stall is high and bytes keep
// flowing; only a second finished frame waiting behind it raises in_stall.
// reset: burst count, pending flag and out_valid clear, config registers load
// 1024 / 5 / 670; frame store contents are left as they are.
`default_nettype none

module rc_receiver_frame_decoder_top
    import rcfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_data_reg;
    out_word_t decoded;
    frame_t    frame;
    logic      pending;
    logic      drain;
    logic      advance;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_CHANNEL_OFFSET: cfg_next.channel_offset = cfg_data[10:0];
                REG_DEADBAND:       cfg_next.deadband       = cfg_data[9:0];
                REG_ABNORMAL_LIMIT: cfg_next.abnormal_limit = cfg_data[10:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_offset <= OFFSET_RESET;
            cfg_reg.deadband       <= DEADBAND_RESET;
            cfg_reg.abnormal_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign drain   = !out_valid_reg || !out_stall;
    assign advance = pending && drain;

    rcfd_frame_buffer u_buffer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .drain    (drain),
        .in_stall (in_stall),
        .pending  (pending),
        .frame    (frame)
    );

    rcfd_frame_decode u_decode (
        .frame  (frame),
        .cfg    (cfg_reg),
        .result (decoded)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= decoded;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[design/rcfd_checker.sv]
// port-level checks for the rc frame decoder, bound to the top level
// depends on rcfd_pkg and rc_receiver_frame_decoder_top_assert.svh
`default_nettype none

`include "rc_receiver_frame_decoder_top_assert.svh"

module rcfd_checker
    import rcfd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_word_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_data
);

    `RCFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled word dropped")
    `RCFD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled word changed")
    `RCFD_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a blocked result")
    // idle word taken, then the pending flag, then out_valid
    `RCFD_ASSERT_NOW(a_word_after_idle, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall && in_data.mode == MODE_IDLE, 2), "word without an idle event")

endmodule

bind rc_receiver_frame_decoder_top rcfd_checker u_rcfd_checker (.*);

`default_nettype wire
